/* src/edm_pkg.sv */
// Shared types and constants for the edit distance name matcher.
`default_nettype none
package edm_pkg;

  localparam int MAX_LEN   = 32;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int QIDX_W    = $clog2(MAX_LEN);
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W    = 6;

  typedef enum logic [1:0] {
    ACT_NEW   = 2'd0,
    ACT_QBYTE = 2'd1,
    ACT_CBYTE = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR    = 2'd2;

  typedef struct packed {
    action_t    action;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              similar;
    logic              too_long;
  } out_item_t;

  typedef struct packed {
    logic new_query;
    logic query_byte;
    logic cand_first;
    logic cand_over;
    logic finish;
    logic cell_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic qlen_zero;
    logic cand_full;
    logic last_cell;
  } dp_status_t;

endpackage
`default_nettype wire

/* src/edm_ctrl.sv */
// Controller state machine: accepts items and sequences the column update.
`default_nettype none
module edm_ctrl
  import edm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire action_t    action,
  input  wire dp_status_t status,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CELL = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r == ST_CELL);
  assign accept = start && !busy;

  always_comb begin
    cmd            = '0;
    cmd.new_query  = accept && (action == ACT_NEW);
    cmd.query_byte = accept && (action == ACT_QBYTE);
    cmd.cand_first = accept && (action == ACT_CBYTE) && !status.cand_full;
    cmd.cand_over  = accept && (action == ACT_CBYTE) && status.cand_full;
    cmd.finish     = accept && (action == ACT_END);
    cmd.cell_step  = (state_r == ST_CELL);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.cand_first && !status.qlen_zero) begin
          state_nxt = ST_CELL;
        end
      end
      ST_CELL: begin
        if (status.last_cell) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/edm_datapath.sv */
// Datapath: query store, distance column, cell arithmetic and result register.
`default_nettype none
module edm_datapath
  import edm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_item_t             in_item,
  input  wire ctrl_cmd_t            cmd,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output dp_status_t                status,
  output logic                      out_valid,
  output out_item_t                 out_item
);

  logic [7:0]       qbytes_r [MAX_LEN];
  logic [LEN_W-1:0] col_r    [1:MAX_LEN];
  logic [MAX_LEN:1] colv_r;
  logic [LEN_W-1:0] qlen_r, clen_r, idx_r, diag_r, left_r;
  logic             qovf_r, covf_r;
  logic [7:0]       sym_r;
  logic [CFG_W-1:0] short_limit_r, short_thr_r, long_thr_r;
  logic             out_valid_r;
  out_item_t        out_item_r, result;

  logic [LEN_W-1:0] rd_idx, rd_val, clen_inc, cell_val, thr;
  logic [LEN_W:0]   up_inc, left_inc, diag_sum, min_ab, min_abc;
  logic             cost, clear_cand;

  assign clear_cand = cmd.new_query || cmd.query_byte || cmd.finish;

  // Column entry zero always equals the candidate length, so it is read from clen_r.
  // Any other entry without its valid bit reads as its own index.
  assign rd_idx   = cmd.cell_step ? idx_r : qlen_r;
  assign rd_val   = (rd_idx == '0) ? clen_r :
                    (colv_r[rd_idx] ? col_r[rd_idx] : rd_idx);
  assign clen_inc = clen_r + LEN_W'(1);

  assign cost     = (qbytes_r[QIDX_W'(idx_r - LEN_W'(1))] != sym_r);
  assign up_inc   = {1'b0, rd_val} + (LEN_W+1)'(1);
  assign left_inc = {1'b0, left_r} + (LEN_W+1)'(1);
  assign diag_sum = {1'b0, diag_r} + (LEN_W+1)'(cost);
  assign min_ab   = (up_inc < left_inc) ? up_inc : left_inc;
  assign min_abc  = (min_ab < diag_sum) ? min_ab : diag_sum;
  assign cell_val = min_abc[LEN_W-1:0];

  assign status.qlen_zero = (qlen_r == '0);
  assign status.cand_full = (clen_r >= LEN_W'(MAX_LEN));
  assign status.last_cell = (idx_r == qlen_r);

  always_comb begin
    thr = (qlen_r <= short_limit_r) ? short_thr_r : long_thr_r;
    result.distance = DIST_W'(rd_val);
    result.similar  = (rd_val != '0) && (rd_val <= thr);
    result.too_long = covf_r || qovf_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_limit_r <= CFG_W'(3);
      short_thr_r   <= CFG_W'(1);
      long_thr_r    <= CFG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_LIMIT: short_limit_r <= cfg_data;
        CFG_SHORT_THR:   short_thr_r   <= cfg_data;
        CFG_LONG_THR:    long_thr_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Query store.
  always_ff @(posedge clk) begin
    if (cmd.query_byte && (qlen_r < LEN_W'(MAX_LEN))) begin
      qbytes_r[qlen_r[QIDX_W-1:0]] <= in_item.symbol;
    end
  end

  // Column entries; validity is tracked separately.
  always_ff @(posedge clk) begin
    if (cmd.cell_step) begin
      col_r[idx_r] <= cell_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colv_r <= '0;
    end else if (clear_cand) begin
      colv_r <= '0;
    end else if (cmd.cell_step) begin
      colv_r[idx_r] <= 1'b1;
    end
  end

  // Cell sweep registers.
  always_ff @(posedge clk) begin
    if (cmd.cand_first) begin
      diag_r <= clen_r;
      left_r <= clen_inc;
      idx_r  <= LEN_W'(1);
      sym_r  <= in_item.symbol;
    end else if (cmd.cell_step) begin
      diag_r <= rd_val;
      left_r <= cell_val;
      idx_r  <= idx_r + LEN_W'(1);
    end
  end

  // Lengths and overflow flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= '0;
      qovf_r <= 1'b0;
      clen_r <= '0;
      covf_r <= 1'b0;
    end else begin
      if (cmd.new_query) begin
        qlen_r <= '0;
        qovf_r <= 1'b0;
      end else if (cmd.query_byte) begin
        if (qlen_r < LEN_W'(MAX_LEN)) begin
          qlen_r <= qlen_r + LEN_W'(1);
        end else begin
          qovf_r <= 1'b1;
        end
      end
      if (clear_cand) begin
        clen_r <= '0;
        covf_r <= 1'b0;
      end else if (cmd.cand_first) begin
        clen_r <= clen_inc;
      end else if (cmd.cand_over) begin
        covf_r <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

/* src/edit_distance_name_matcher.sv */
// Top level of the edit distance name matcher: controller plus datapath.
// A result appears in the cycle after its end-candidate item is accepted.
// A candidate byte within MAX_LEN against a non-empty query holds busy while the single
// cell unit sweeps the distance column, one query position per cycle; items wait meanwhile.
// Other items and dropped candidate bytes never raise busy. The receiver cannot stall.
// Reset is synchronous, active low; it clears the query and the column and restores the
// register defaults.
`default_nettype none
module edit_distance_name_matcher
  import edm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // The controller decides which item is taken and walks the column sweep.
  // The datapath holds all string and column state and reports back the few
  // conditions that steer the controller: an empty query, a full candidate
  // and the last query position of the sweep.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  edm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_item.action),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // The column lives in flip-flops with one valid bit per entry, so clearing
  // it for a new candidate only drops the valid bits: an invalid entry reads as its index.
  // Entry zero is the candidate length itself and needs no storage of its own.
  edm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

/* src/edm_checker.sv */
// Port-level checker for the edit distance name matcher, bound to the top level.
`default_nettype none
module edm_checker
  import edm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  logic end_taken;
  assign end_taken = start && !busy && (in_item.action == ACT_END);

  a_result_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
    end_taken |=> out_valid)
    else $error("result missing after end of candidate");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(end_taken))
    else $error("result without an end of candidate");

  a_busy_from_cand_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_item.action == ACT_CBYTE)))
    else $error("busy raised without a candidate byte");

  a_similar_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.similar) |-> (out_item.distance != '0))
    else $error("similar flagged on zero distance");

endmodule

bind edit_distance_name_matcher edm_checker u_edm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

/* tb/edm_check_pkg.sv */
// Scoreboard for the edit distance name matcher: Levenshtein predictor and expected-result store.
package edm_check_pkg;
  import edm_pkg::*;

  class name_match_checker;
    logic [CFG_W-1:0] short_limit;
    logic [CFG_W-1:0] short_thr;
    logic [CFG_W-1:0] long_thr;
    logic [7:0]       query_mem [MAX_LEN];
    int unsigned      query_len;
    int unsigned      cand_len;
    int unsigned      dp_column [MAX_LEN+1];
    bit               cand_over;
    bit               query_over;
    out_item_t        expected_matches [$];
    int unsigned      errors;

    function new();
      short_limit = 6'd3;
      short_thr   = 6'd1;
      long_thr    = 6'd2;
      foreach (query_mem[i]) query_mem[i] = 8'h00;
      query_len  = 0;
      query_over = 1'b0;
      errors     = 0;
      clear_candidate();
    endfunction

    function void clear_candidate();
      foreach (dp_column[i]) dp_column[i] = i;
      cand_len  = 0;
      cand_over = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SHORT_LIMIT: short_limit = val;
        CFG_SHORT_THR:   short_thr   = val;
        CFG_LONG_THR:    long_thr    = val;
        default: ;
      endcase
    endfunction

    // One candidate byte moves the column one step along the candidate.
    function void advance_column(logic [7:0] sym);
      int unsigned diag;
      int unsigned up;
      int unsigned best;
      int unsigned i;
      if (cand_len >= MAX_LEN) begin
        cand_over = 1'b1;
        return;
      end
      cand_len++;
      diag = dp_column[0];
      dp_column[0] = cand_len;
      for (i = 1; i <= query_len; i++) begin
        up   = dp_column[i];
        best = diag + ((query_mem[i-1] == sym) ? 0 : 1);
        if (up + 1 < best) best = up + 1;
        if (dp_column[i-1] + 1 < best) best = dp_column[i-1] + 1;
        dp_column[i] = best;
        diag = up;
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t   want;
      int unsigned col_dist;
      int unsigned thr;
      case (it.action)
        ACT_NEW: begin
          query_len  = 0;
          query_over = 1'b0;
          clear_candidate();
        end
        ACT_QBYTE: begin
          if (query_len < MAX_LEN) begin
            query_mem[query_len] = it.symbol;
            query_len++;
          end else begin
            query_over = 1'b1;
          end
          clear_candidate();
        end
        ACT_CBYTE: advance_column(it.symbol);
        default: begin
          col_dist = dp_column[query_len];
          thr  = (query_len <= short_limit) ? short_thr : long_thr;
          want.distance = (col_dist > 63) ? 6'd63 : DIST_W'(col_dist);
          want.similar  = (col_dist != 0) && (col_dist <= thr);
          want.too_long = cand_over || query_over;
          expected_matches.insert(expected_matches.size(), want);
          clear_candidate();
        end
      endcase
    endfunction

    function void flag(string msg);
      if (errors < 10) $display("%s", msg);
      errors++;
    endfunction

    function void check_match(out_item_t got);
      out_item_t want;
      if (expected_matches.size() == 0) begin
        flag($sformatf("unexpected result: distance=%0d similar=%0b too_long=%0b",
                       got.distance, got.similar, got.too_long));
        return;
      end
      want = expected_matches.pop_front();
      if (got.distance !== want.distance || got.similar !== want.similar ||
          got.too_long !== want.too_long)
        flag($sformatf({"mismatch: expected distance=%0d similar=%0b too_long=%0b,",
                        " got distance=%0d similar=%0b too_long=%0b"},
                       want.distance, want.similar, want.too_long,
                       got.distance, got.similar, got.too_long));
    endfunction

    function int unsigned pending();
      return expected_matches.size();
    endfunction

    function void close_out();
      if (expected_matches.size() != 0)
        flag($sformatf("%0d expected results never arrived", expected_matches.size()));
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
// Self-checking testbench for the edit distance name matcher.
module tb_top;
  import edm_pkg::*;
  import edm_check_pkg::*;

  // Cycles without any accepted item, result or register write before the run is abandoned.
  // The slowest legal wait is a candidate byte against a full query behind a
  // long random sender gap, so this leaves a wide margin.
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1150;
  localparam int N_PHASES    = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SHORT_LIMIT;
  logic [CFG_W-1:0]     cfg_data  = '0;

  name_match_checker matcher = new();

  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  // Chance in percent that the sender idles once more before offering an item.
  int unsigned gap_pct      = 0;

  edit_distance_name_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // All sampling happens here, on pre-edge values. The result is checked before the item of
  // the same edge is noted: a result always belongs to an item accepted at an earlier edge.
  // Register writes are mirrored into the predictor as the block takes them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) matcher.check_match(out_item);
      if (cfg_we) matcher.write_reg(cfg_index, cfg_data);
      if (start && !busy) matcher.note_item(in_item);
      if (out_valid || cfg_we || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The watchdog ends a hung run.
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one item and returns at the edge that accepts it. Start is left high, so the
  // caller either offers the next item or lowers start in this same time step.
  task automatic send_item(action_t act, logic [7:0] sym);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{action: act, symbol: sym};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Lowers start and waits until every expected result is in and the block is idle. A
  // candidate byte gives no result but keeps the block sweeping its column, hence the
  // busy check, and a closing wait follows before the next phase.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (matcher.pending() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all three registers on back-to-back cycles; only called while the block is idle.
  task automatic load_config(logic [CFG_W-1:0] lim, logic [CFG_W-1:0] sthr,
                             logic [CFG_W-1:0] lthr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SHORT_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_index <= CFG_SHORT_THR;
    cfg_data  <= sthr;
    @(posedge clk);
    cfg_index <= CFG_LONG_THR;
    cfg_data  <= lthr;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly short names; now and then one that runs past the 32-byte store so the
  // overflow flag and truncation get exercised.
  function automatic int unsigned pick_length();
    if ($urandom_range(99) < 6) return $urandom_range(36, 30);
    return $urandom_range(8);
  endfunction

  // A narrow alphabet makes matching bytes common; the wide one covers every symbol bit.
  function automatic logic [7:0] pick_symbol(bit narrow);
    if (!narrow) return 8'($urandom);
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h41;
      default: return 8'h42;
    endcase
  endfunction

  // Random traffic up to the given running item count. Most of it is a new query followed
  // by a few candidates, each either a few edits away from the query or unrelated. The rest
  // is loose items in any order, and now and then a query byte cuts into a candidate.
  task automatic run_matches(int unsigned target);
    logic [7:0]  query [$];
    logic [7:0]  cand [$];
    int unsigned qn;
    int unsigned n;
    int unsigned pos;
    bit          narrow;
    while (items_sent < target) begin
      if ($urandom_range(99) < 8) begin
        send_item(action_t'($urandom_range(3)), 8'($urandom));
      end else begin
        narrow = 1'($urandom_range(1));
        qn = pick_length();
        query.delete();
        repeat (qn) query.insert(query.size(), pick_symbol(narrow));
        send_item(ACT_NEW, 8'($urandom));
        foreach (query[j]) send_item(ACT_QBYTE, query[j]);
        repeat ($urandom_range(4, 1)) begin
          cand = query;
          if ($urandom_range(3) == 0) begin
            cand.delete();
            n = pick_length();
            repeat (n) cand.insert(cand.size(), pick_symbol(narrow));
          end
          repeat ($urandom_range(3)) begin
            pos = $urandom_range(cand.size());
            case ($urandom_range(2))
              0: cand.insert(pos, pick_symbol(narrow));
              1: if (pos < cand.size()) cand.delete(pos);
              default: if (pos < cand.size()) cand[pos] = pick_symbol(narrow);
            endcase
          end
          foreach (cand[j]) begin
            send_item(ACT_CBYTE, cand[j]);
            if ($urandom_range(49) == 0) send_item(ACT_QBYTE, pick_symbol(narrow));
          end
          send_item(ACT_END, 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings (short limit 3, thresholds 1 and 2), no idling.
    // The query uses the extreme byte values; the ignored symbol of the new-query item and
    // of the first end-candidate item is set high to show it has no effect.
    send_item(ACT_NEW,   8'hFF);
    send_item(ACT_QBYTE, 8'h00);
    send_item(ACT_QBYTE, 8'hFF);
    send_item(ACT_QBYTE, 8'h41);
    // An empty candidate: the distance is the query length.
    send_item(ACT_END,   8'hFF);
    // An exact match gives zero and is never similar.
    send_item(ACT_CBYTE, 8'h00);
    send_item(ACT_CBYTE, 8'hFF);
    send_item(ACT_CBYTE, 8'h41);
    send_item(ACT_END,   8'h00);
    // One substitution on a short query is within the short threshold.
    send_item(ACT_CBYTE, 8'h00);
    send_item(ACT_CBYTE, 8'hFF);
    send_item(ACT_CBYTE, 8'h42);
    send_item(ACT_END,   8'h00);
    // A query byte in the middle of a candidate extends the query and drops the partial
    // candidate; the query is now four bytes and so no longer short.
    send_item(ACT_CBYTE, 8'h00);
    send_item(ACT_QBYTE, 8'h42);
    send_item(ACT_END,   8'h00);
    send_item(ACT_CBYTE, 8'h00);
    send_item(ACT_CBYTE, 8'hFF);
    send_item(ACT_CBYTE, 8'h41);
    send_item(ACT_CBYTE, 8'h42);
    send_item(ACT_END,   8'h00);
    // Three deletions against the longer query.
    send_item(ACT_CBYTE, 8'hFF);
    send_item(ACT_END,   8'h00);
    settle();

    // Random phases: each starts from an idle block with a fresh register setting, the
    // extremes first, and rotates the sender idling between none, heavy and light.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       load_config(6'd0,  6'd0,  6'd0);
        1:       load_config(6'd63, 6'd63, 6'd63);
        2:       load_config(6'd32, 6'd32, 6'd32);
        3:       load_config(6'd3,  6'd1,  6'd2);
        default: load_config(6'($urandom_range(12)), 6'($urandom_range(6)),
                             6'($urandom_range(63)));
      endcase
      case (p % 3)
        0:       gap_pct = 0;
        1:       gap_pct = 73;
        default: gap_pct = 6;
      endcase
      run_matches(ITEM_TARGET * (p + 1) / N_PHASES);
      settle();
    end

    matcher.close_out();
    if (matcher.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/edm_pkg.sv
src/edm_ctrl.sv
src/edm_datapath.sv
src/edit_distance_name_matcher.sv
src/edm_checker.sv
tb/edm_check_pkg.sv
tb/tb_top.sv
